// ----- rtl/core/transmission_target_selector_assert.svh -----
// Assertion helpers; they expect clk and rst_n in the enclosing scope.
`ifndef TRANSMISSION_TARGET_SELECTOR_ASSERT_SVH
`define TRANSMISSION_TARGET_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tts assertion failed");
`define TTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tts assertion failed");
`else
`define TTS_ASSERT_IMP(lbl, ante, cons)
`define TTS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/tts_pkg.sv -----
package tts_pkg;

  localparam int CAL_POINTS  = 7;
  localparam int NUM_BUCKETS = 10;

  localparam int TGT_W    = 12;
  localparam int SPEED_W  = 13;
  localparam int LEVER_W  = 10;
  localparam int MODE_W   = 8;
  localparam int BUCKET_W = 4;

  // interpolation datapath widths
  localparam int OFF_W  = 12;
  localparam int DY_W   = 13;
  localparam int PROD_W = OFF_W + 1 + DY_W;
  localparam int N_W    = PROD_W + 2;
  localparam int DEN_W  = OFF_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int SUM_W  = N_W + 1;
  localparam int CNT_W  = $clog2(N_W);

  localparam logic [MODE_W-1:0] MODE_AUTO   = 8'd0;
  localparam logic [MODE_W-1:0] MODE_MANUAL = 8'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSE  = 8'd2;
  localparam logic [MODE_W-1:0] MODE_SAFETY = 8'd9;

  localparam logic [BUCKET_W-1:0] BUCKET_AUTO  = 4'd5;
  localparam logic [BUCKET_W-1:0] BUCKET_FAULT = 4'd4;
  localparam logic [BUCKET_W-1:0] BUCKET_RESET = 4'd5;

  localparam logic [TGT_W-1:0] NEUTRAL_RESET = 12'd2836;
  localparam logic [TGT_W-1:0] TGT_MAX       = 12'd4095;

  localparam logic signed [SPEED_W-1:0] CAL_X [CAL_POINTS] =
    '{13'sd0, 13'sd400, 13'sd870, 13'sd940, 13'sd1000, 13'sd1250, 13'sd1500};
  localparam logic [TGT_W-1:0] CAL_Y [CAL_POINTS] =
    '{12'd2836, 12'd2452, 12'd2421, 12'd2404, 12'd2288, 12'd2240, 12'd2200};

  localparam logic [LEVER_W-1:0] LEVER_THR [NUM_BUCKETS-1] =
    '{10'd931, 10'd838, 10'd746, 10'd654, 10'd562, 10'd469, 10'd377, 10'd285,
      10'd192};
  localparam logic [TGT_W-1:0] BUCKET_TGT [NUM_BUCKETS] =
    '{12'd3138, 12'd3063, 12'd2987, 12'd2912, 12'd2836, 12'd2616, 12'd2534,
      12'd2452, 12'd2370, 12'd2288};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic                      radio_good;
    logic [MODE_W-1:0]         mode_request;
    logic                      speed_valid;
    logic signed [SPEED_W-1:0] speed_mm_s;
    logic [LEVER_W-1:0]        lever_value;
    logic                      fault_raise;
    logic                      steer_response_ok;
  } in_item_t;

  typedef struct packed {
    logic [TGT_W-1:0]    drive_target;
    logic [BUCKET_W-1:0] bucket_index;
    logic [MODE_W-1:0]   effective_mode;
    logic                fault_active;
    logic                fault_cleared;
  } out_item_t;

endpackage

// ----- rtl/core/tts_in_if.sv -----
interface tts_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       radio_good;
  logic [tts_pkg::MODE_W-1:0]                 mode_request;
  logic                                       speed_valid;
  logic signed [tts_pkg::SPEED_W-1:0]         speed_mm_s;
  logic [tts_pkg::LEVER_W-1:0]                lever_value;
  logic                                       fault_raise;
  logic                                       steer_response_ok;

  modport source (
    output valid, radio_good, mode_request, speed_valid, speed_mm_s, lever_value,
           fault_raise, steer_response_ok,
    input  ready
  );
  modport sink (
    input  valid, radio_good, mode_request, speed_valid, speed_mm_s, lever_value,
           fault_raise, steer_response_ok,
    output ready
  );
endinterface

// ----- rtl/core/tts_out_if.sv -----
interface tts_out_if;
  logic                              valid;
  logic                              ready;
  logic [tts_pkg::TGT_W-1:0]         drive_target;
  logic [tts_pkg::BUCKET_W-1:0]      bucket_index;
  logic [tts_pkg::MODE_W-1:0]        effective_mode;
  logic                              fault_active;
  logic                              fault_cleared;

  modport source (
    output valid, drive_target, bucket_index, effective_mode, fault_active,
           fault_cleared,
    input  ready
  );
  modport sink (
    input  valid, drive_target, bucket_index, effective_mode, fault_active,
           fault_cleared,
    output ready
  );
endinterface

// ----- rtl/core/tts_datapath.sv -----
module tts_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tts_pkg::cmd_t                  cmd,
  input  tts_pkg::in_item_t              in_item,
  input  logic                           cfg_we,
  input  logic [tts_pkg::TGT_W-1:0]      cfg_wdata,
  output tts_pkg::out_item_t             out_item
);

  localparam int CP = tts_pkg::CAL_POINTS;
  localparam int NB = tts_pkg::NUM_BUCKETS;

  // captured request
  tts_pkg::in_item_t                  req_r;
  logic [tts_pkg::MODE_W-1:0]         mode_r;

  // setup results
  logic [tts_pkg::TGT_W-1:0]          base_r, base_nxt;
  logic [tts_pkg::OFF_W-1:0]          off_r, off_nxt;
  logic [tts_pkg::OFF_W-1:0]          dx_r, dx_nxt;
  logic signed [tts_pkg::DY_W-1:0]    dy_r, dy_nxt;
  logic [tts_pkg::BUCKET_W-1:0]       man_bkt_r, man_bkt_nxt;
  logic [tts_pkg::TGT_W-1:0]          man_tgt_r;

  // divider
  logic signed [tts_pkg::PROD_W-1:0]  prod_c;
  logic signed [tts_pkg::N_W-1:0]     n_c;
  logic                               neg_r;
  logic [tts_pkg::DEN_W-1:0]          den_r;
  logic [tts_pkg::N_W-1:0]            quo_r;
  logic [tts_pkg::REM_W-1:0]          rem_r, rem_sh_c;
  logic                               ge_c;

  // persistent state
  logic [tts_pkg::TGT_W-1:0]          neutral_r;
  logic                               fault_r, fault_nxt;
  logic                               pause_r, pause_nxt;
  logic [tts_pkg::BUCKET_W-1:0]       held_r, held_nxt;

  logic signed [tts_pkg::SUM_W-1:0]   q_c, sum_c;
  logic [tts_pkg::TGT_W-1:0]          auto_tgt_c, tgt_c;
  logic                               clr_c;

  // segment search and lever quantizer
  always_comb begin
    logic signed [tts_pkg::SPEED_W-1:0] dxs;
    base_nxt    = tts_pkg::CAL_Y[CP-1];
    off_nxt     = '0;
    dx_nxt      = tts_pkg::OFF_W'(1);
    dy_nxt      = '0;
    dxs         = '0;
    if (req_r.speed_mm_s <= tts_pkg::CAL_X[0]) begin
      base_nxt = tts_pkg::CAL_Y[0];
    end else if (req_r.speed_mm_s >= tts_pkg::CAL_X[CP-1]) begin
      base_nxt = tts_pkg::CAL_Y[CP-1];
    end else begin
      // descending scan so the lowest matching segment wins
      for (int i = CP - 1; i >= 1; i--) begin
        if (req_r.speed_mm_s <= tts_pkg::CAL_X[i]) begin
          dxs = tts_pkg::CAL_X[i] - tts_pkg::CAL_X[i-1];
          if (dxs <= 0) begin
            base_nxt = tts_pkg::CAL_Y[i];
            off_nxt  = '0;
            dx_nxt   = tts_pkg::OFF_W'(1);
            dy_nxt   = '0;
          end else begin
            base_nxt = tts_pkg::CAL_Y[i-1];
            off_nxt  = tts_pkg::OFF_W'(req_r.speed_mm_s - tts_pkg::CAL_X[i-1]);
            dx_nxt   = tts_pkg::OFF_W'(dxs);
            dy_nxt   = $signed({1'b0, tts_pkg::CAL_Y[i]})
                     - $signed({1'b0, tts_pkg::CAL_Y[i-1]});
          end
        end
      end
    end

    man_bkt_nxt = tts_pkg::BUCKET_W'(NB - 1);
    for (int i = NB - 2; i >= 0; i--) begin
      if (req_r.lever_value >= tts_pkg::LEVER_THR[i]) begin
        man_bkt_nxt = tts_pkg::BUCKET_W'(i);
      end
    end
  end

  assign prod_c = $signed({1'b0, off_r}) * dy_r;
  // 2*num + dx
  assign n_c = {{(tts_pkg::N_W - tts_pkg::PROD_W - 1){prod_c[tts_pkg::PROD_W-1]}},
                prod_c, 1'b0}
             + {{(tts_pkg::N_W - tts_pkg::OFF_W){1'b0}}, dx_r};

  assign rem_sh_c = {rem_r[tts_pkg::REM_W-2:0], quo_r[tts_pkg::N_W-1]};
  assign ge_c     = rem_sh_c >= {1'b0, den_r};

  // floor of a negative quotient rounds away from zero on a nonzero remainder
  always_comb begin
    if (neg_r) begin
      q_c = -($signed({1'b0, quo_r}) + $signed({{(tts_pkg::SUM_W-1){1'b0}},
                                                (rem_r != '0)}));
    end else begin
      q_c = $signed({1'b0, quo_r});
    end
    sum_c = $signed({{(tts_pkg::SUM_W - tts_pkg::TGT_W){1'b0}}, base_r}) + q_c;
    if (sum_c[tts_pkg::SUM_W-1]) begin
      auto_tgt_c = '0;
    end else if (sum_c > $signed({{(tts_pkg::SUM_W - tts_pkg::TGT_W){1'b0}},
                                  tts_pkg::TGT_MAX})) begin
      auto_tgt_c = tts_pkg::TGT_MAX;
    end else begin
      auto_tgt_c = sum_c[tts_pkg::TGT_W-1:0];
    end
  end

  // mode selection and fault latch
  always_comb begin
    tgt_c     = neutral_r;
    held_nxt  = held_r;
    fault_nxt = fault_r;
    pause_nxt = pause_r;
    clr_c     = 1'b0;
    if (mode_r == tts_pkg::MODE_AUTO) begin
      tgt_c    = req_r.speed_valid ? auto_tgt_c : neutral_r;
      held_nxt = tts_pkg::BUCKET_AUTO;
    end else if (mode_r == tts_pkg::MODE_MANUAL) begin
      tgt_c    = man_tgt_r;
      held_nxt = man_bkt_r;
    end
    if (fault_r) begin
      if (mode_r == tts_pkg::MODE_PAUSE) begin
        pause_nxt = 1'b1;
      end
      if (mode_r == tts_pkg::MODE_MANUAL && pause_r && req_r.steer_response_ok &&
          tgt_c == neutral_r) begin
        fault_nxt = 1'b0;
        pause_nxt = 1'b0;
        clr_c     = 1'b1;
      end else begin
        tgt_c    = neutral_r;
        held_nxt = tts_pkg::BUCKET_FAULT;
      end
    end
    // watchdog acts after the decision
    if (req_r.fault_raise) begin
      fault_nxt = 1'b1;
      pause_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_item;
      mode_r <= in_item.radio_good ? in_item.mode_request : tts_pkg::MODE_SAFETY;
    end
    if (cmd.setup) begin
      base_r    <= base_nxt;
      off_r     <= off_nxt;
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      man_bkt_r <= man_bkt_nxt;
      man_tgt_r <= tts_pkg::BUCKET_TGT[man_bkt_nxt];
    end
    if (cmd.mul) begin
      neg_r <= n_c[tts_pkg::N_W-1];
      quo_r <= n_c[tts_pkg::N_W-1] ? tts_pkg::N_W'(-n_c) : tts_pkg::N_W'(n_c);
      rem_r <= '0;
      den_r <= {dx_r, 1'b0};
    end else if (cmd.div_step) begin
      rem_r <= ge_c ? (rem_sh_c - {1'b0, den_r}) : rem_sh_c;
      quo_r <= {quo_r[tts_pkg::N_W-2:0], ge_c};
    end
    if (cmd.fin) begin
      out_item.drive_target   <= tgt_c;
      out_item.bucket_index   <= held_nxt;
      out_item.effective_mode <= mode_r;
      out_item.fault_active   <= fault_nxt;
      out_item.fault_cleared  <= clr_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r <= tts_pkg::NEUTRAL_RESET;
      fault_r   <= 1'b0;
      pause_r   <= 1'b0;
      held_r    <= tts_pkg::BUCKET_RESET;
    end else begin
      if (cfg_we) begin
        neutral_r <= cfg_wdata;
      end
      if (cmd.fin) begin
        fault_r <= fault_nxt;
        pause_r <= pause_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/tts_ctrl.sv -----
`include "transmission_target_selector_assert.svh"

module tts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tts_pkg::cmd_t cmd
);

  tts_pkg::state_t              state_r, state_nxt;
  logic [tts_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tts_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      tts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tts_pkg::ST_SETUP;
        end
      end
      tts_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = tts_pkg::ST_MUL;
      end
      tts_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = tts_pkg::ST_DIV;
      end
      tts_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == tts_pkg::CNT_W'(tts_pkg::N_W - 1)) begin
          state_nxt = tts_pkg::ST_FIN;
        end
      end
      tts_pkg::ST_FIN: begin
        // wait for room in the output register
        if (!out_valid_r || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = tts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  `TTS_ASSERT_NXT(a_load_to_setup, cmd.load, state_r == tts_pkg::ST_SETUP)
  `TTS_ASSERT_NXT(a_fin_sets_valid, cmd.fin, out_valid_r)
  `TTS_ASSERT_IMP(a_div_count, state_r == tts_pkg::ST_DIV, cnt_r <= tts_pkg::CNT_W'(tts_pkg::N_W - 1))

endmodule

// ----- rtl/core/transmission_target_selector.sv -----
// Transmission target selector.
// One request on in_ch is one control tick: radio state, mode request, speed
// command, lever reading and steering fault inputs. For each request exactly
// one result leaves on out_ch: drive target, bucket, effective mode and the
// fault latch status. cfg_we/cfg_wdata write the neutral target; write it only
// while no request is in flight.
// The auto-mode interpolation runs a restoring divider one quotient bit per
// cycle over 28 bits, after the setup and multiply steps and before the finish
// step. A new request can be accepted in the cycle after the previous result
// is loaded; no new request is taken while one is being computed.
// A result waits in the output register while out_ch.ready is low; the next
// request is still accepted and computed, and it is held in the finish step
// until the output register frees.
// Reset (rst_n low at a clock edge) clears the fault latch and pause flag,
// sets the held bucket to 5, restores the neutral target to 2836 and drops
// any request in flight.
module transmission_target_selector (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [tts_pkg::TGT_W-1:0] cfg_wdata,
  tts_in_if.sink                    in_ch,
  tts_out_if.source                 out_ch
);

  tts_pkg::cmd_t      cmd;
  tts_pkg::in_item_t  in_item;
  tts_pkg::out_item_t out_item;

  assign in_item.radio_good        = in_ch.radio_good;
  assign in_item.mode_request      = in_ch.mode_request;
  assign in_item.speed_valid       = in_ch.speed_valid;
  assign in_item.speed_mm_s        = in_ch.speed_mm_s;
  assign in_item.lever_value       = in_ch.lever_value;
  assign in_item.fault_raise       = in_ch.fault_raise;
  assign in_item.steer_response_ok = in_ch.steer_response_ok;

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tts_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

  assign out_ch.drive_target   = out_item.drive_target;
  assign out_ch.bucket_index   = out_item.bucket_index;
  assign out_ch.effective_mode = out_item.effective_mode;
  assign out_ch.fault_active   = out_item.fault_active;
  assign out_ch.fault_cleared  = out_item.fault_cleared;

endmodule

// ----- bench/transmission_target_selector_tb.sv -----
module transmission_target_selector_tb;
  import tts_pkg::*;

  localparam int HOLD_OFF     = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 265;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TGT_W-1:0] cfg_wdata;

  tts_in_if  in_ch();
  tts_out_if out_ch();

  transmission_target_selector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  logic [TGT_W-1:0]    neutral_q;
  logic                fault_q;
  logic                pause_q;
  logic [BUCKET_W-1:0] held_q;

  out_item_t pending_results[$];
  dir_row_t  plan[$];

  int  errors = 0;
  int  cycle_cnt = 0;
  int  ticks_sent = 0;
  int  results_seen = 0;
  int  recoveries = 0;
  int  interp_ticks = 0;
  int  hold_ticks = 0;
  bit  tx_quiet = 0;
  bit  rx_quiet = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // calibration curve, mm/s -> target
  function automatic longint cal_speed(int i);
    case (i)
      0: return 0;
      1: return 400;
      2: return 870;
      3: return 940;
      4: return 1000;
      5: return 1250;
      default: return 1500;
    endcase
  endfunction

  function automatic longint cal_level(int i);
    case (i)
      0: return 2836;
      1: return 2452;
      2: return 2421;
      3: return 2404;
      4: return 2288;
      5: return 2240;
      default: return 2200;
    endcase
  endfunction

  function automatic int lever_threshold(int i);
    case (i)
      0: return 931;
      1: return 838;
      2: return 746;
      3: return 654;
      4: return 562;
      5: return 469;
      6: return 377;
      7: return 285;
      default: return 192;
    endcase
  endfunction

  function automatic logic [TGT_W-1:0] bucket_target(int b);
    case (b)
      0: return 12'd3138;
      1: return 12'd3063;
      2: return 12'd2987;
      3: return 12'd2912;
      4: return 12'd2836;
      5: return 12'd2616;
      6: return 12'd2534;
      7: return 12'd2452;
      8: return 12'd2370;
      default: return 12'd2288;
    endcase
  endfunction

  function automatic logic [TGT_W-1:0] calib_target(logic signed [SPEED_W-1:0] spd);
    longint x, dx, n2, d2, q;
    x = spd;
    if (x <= cal_speed(0)) return TGT_W'(cal_level(0));
    if (x >= cal_speed(CAL_POINTS-1)) return TGT_W'(cal_level(CAL_POINTS-1));
    for (int i = 1; i < CAL_POINTS; i++) begin
      if (x <= cal_speed(i)) begin
        dx = cal_speed(i) - cal_speed(i-1);
        n2 = 2 * (x - cal_speed(i-1)) * (cal_level(i) - cal_level(i-1)) + dx;
        d2 = 2 * dx;
        q = n2 / d2;
        // round half up needs floor, SV truncates toward zero
        if (n2 % d2 != 0 && n2 < 0) q = q - 1;
        q = q + cal_level(i-1);
        if (q < 0) q = 0;
        if (q > 4095) q = 4095;
        return q[TGT_W-1:0];
      end
    end
    return TGT_W'(cal_level(0));
  endfunction

  function automatic logic [BUCKET_W-1:0] lever_bucket(logic [LEVER_W-1:0] lv);
    for (int i = 0; i < NUM_BUCKETS-1; i++)
      if (lv >= lever_threshold(i)) return BUCKET_W'(i);
    return BUCKET_W'(NUM_BUCKETS-1);
  endfunction

  // one control tick of the predictor; updates its state
  function automatic out_item_t tick_outcome(in_item_t it);
    out_item_t           r;
    logic [MODE_W-1:0]   m;
    logic [TGT_W-1:0]    tgt;
    logic [BUCKET_W-1:0] bkt;
    logic                clr;
    m   = it.radio_good ? it.mode_request : MODE_SAFETY;
    tgt = neutral_q;
    bkt = held_q;
    clr = 1'b0;
    if (m == MODE_AUTO) begin
      tgt = it.speed_valid ? calib_target(it.speed_mm_s) : neutral_q;
      bkt = BUCKET_AUTO;
      if (it.speed_valid && it.speed_mm_s > 0 && it.speed_mm_s < 1500)
        interp_ticks++;
    end else if (m == MODE_MANUAL) begin
      bkt = lever_bucket(it.lever_value);
      tgt = bucket_target(bkt);
    end
    if (fault_q) begin
      if (m == MODE_PAUSE) pause_q = 1'b1;
      if (m == MODE_MANUAL && pause_q && it.steer_response_ok && tgt == neutral_q) begin
        fault_q = 1'b0;
        pause_q = 1'b0;
        clr = 1'b1;
        recoveries++;
      end else begin
        tgt = neutral_q;
        bkt = BUCKET_FAULT;
        hold_ticks++;
      end
    end
    held_q = bkt;
    // watchdog runs after the decision
    if (it.fault_raise) begin
      fault_q = 1'b1;
      pause_q = 1'b0;
    end
    r.drive_target   = tgt;
    r.bucket_index   = bkt;
    r.effective_mode = m;
    r.fault_active   = fault_q;
    r.fault_cleared  = clr;
    return r;
  endfunction

  function automatic in_item_t req(bit rg, logic [MODE_W-1:0] m, bit sv, int spd,
                                   int lv, bit fr, bit ok);
    in_item_t it;
    it.radio_good        = rg;
    it.mode_request      = m;
    it.speed_valid       = sv;
    it.speed_mm_s        = spd[SPEED_W-1:0];
    it.lever_value       = lv[LEVER_W-1:0];
    it.fault_raise       = fr;
    it.steer_response_ok = ok;
    return it;
  endfunction

  function automatic out_item_t res(int tgt, int bkt, logic [MODE_W-1:0] m, bit fa, bit fc);
    out_item_t r;
    r.drive_target   = tgt[TGT_W-1:0];
    r.bucket_index   = bkt[BUCKET_W-1:0];
    r.effective_mode = m;
    r.fault_active   = fa;
    r.fault_cleared  = fc;
    return r;
  endfunction

  // lever reading that lands in bucket b
  function automatic int lever_for_bucket(int b);
    if (b == 0) return $urandom_range(1023, lever_threshold(0));
    if (b == NUM_BUCKETS-1) return $urandom_range(lever_threshold(NUM_BUCKETS-2) - 1, 0);
    return $urandom_range(lever_threshold(b-1) - 1, lever_threshold(b));
  endfunction

  // bucket whose target equals the neutral target, -1 if none
  function automatic int neutral_bucket();
    for (int b = 0; b < NUM_BUCKETS; b++)
      if (bucket_target(b) == neutral_q) return b;
    return -1;
  endfunction

  function automatic int recovery_lever();
    int b;
    b = neutral_bucket();
    if (b < 0) b = $urandom_range(NUM_BUCKETS-1, 0);
    return lever_for_bucket(b);
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    int r, s;
    r = $urandom_range(99, 0);
    if (r < 38) it.mode_request = MODE_AUTO;
    else if (r < 76) it.mode_request = MODE_MANUAL;
    else if (r < 88) it.mode_request = MODE_PAUSE;
    else if (r < 92) it.mode_request = MODE_SAFETY;
    else it.mode_request = MODE_W'($urandom_range(255, 3));
    it.radio_good = ($urandom_range(19, 0) != 0);
    it.speed_valid = ($urandom_range(9, 0) != 0);
    if ($urandom_range(99, 0) < 60) s = $urandom_range(1700, 0) - 100;
    else s = $urandom_range(8191, 0);
    it.speed_mm_s = s[SPEED_W-1:0];
    if ($urandom_range(99, 0) < 30) s = recovery_lever();
    else s = $urandom_range(1023, 0);
    it.lever_value = s[LEVER_W-1:0];
    it.fault_raise = ($urandom_range(29, 0) == 0);
    it.steer_response_ok = ($urandom_range(3, 0) != 0);
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int gap;
    out_item_t pred;
    if ($urandom_range(39, 0) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(13, 0);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid             <= 1'b1;
    in_ch.radio_good        <= it.radio_good;
    in_ch.mode_request      <= it.mode_request;
    in_ch.speed_valid       <= it.speed_valid;
    in_ch.speed_mm_s        <= it.speed_mm_s;
    in_ch.lever_value       <= it.lever_value;
    in_ch.fault_raise       <= it.fault_raise;
    in_ch.steer_response_ok <= it.steer_response_ok;
    do @(posedge clk); while (!in_ch.ready);
    pred = tick_outcome(it);
    pending_results.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  task automatic send_random();
    out_item_t none;
    none = '0;
    send_item(random_request(), 1'b0, none);
  endtask

  // fault raised, some noise, a pause, then a manual request aimed at recovery
  task automatic run_recovery();
    in_item_t it;
    out_item_t none;
    none = '0;
    it = random_request();
    it.fault_raise = 1'b1;
    send_item(it, 1'b0, none);
    repeat ($urandom_range(3, 0)) begin
      it = random_request();
      it.fault_raise = 1'b0;
      send_item(it, 1'b0, none);
    end
    send_item(req(1, MODE_PAUSE, 0, 0, $urandom_range(1023, 0), 0,
                  1'($urandom_range(1, 0))), 1'b0, none);
    repeat ($urandom_range(2, 0)) begin
      it = random_request();
      it.fault_raise = 1'b0;
      if (it.mode_request == MODE_MANUAL) it.steer_response_ok = 1'b0;
      send_item(it, 1'b0, none);
    end
    send_item(req(1, MODE_MANUAL, 1'($urandom_range(1, 0)), $urandom_range(8191, 0),
                  recovery_lever(), $urandom_range(7, 0) == 0, 1), 1'b0, none);
  endtask

  // sender holds off until every expected result is back
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_neutral(logic [TGT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    neutral_q = v;
  endtask

  // result side
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(39, 0) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(13, 0);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got target %0d", $time,
                 out_ch.drive_target);
      end else begin
        want = pending_results.pop_front();
        check_field("drive_target", want.drive_target, out_ch.drive_target);
        check_field("bucket_index", want.bucket_index, out_ch.bucket_index);
        check_field("effective_mode", want.effective_mode, out_ch.effective_mode);
        check_field("fault_active", want.fault_active, out_ch.fault_active);
        check_field("fault_cleared", want.fault_cleared, out_ch.fault_cleared);
      end
    end
  end

  initial begin
    logic [TGT_W-1:0] settings [PHASES];
    int goal;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    in_ch.valid             = 1'b0;
    in_ch.radio_good        = 1'b0;
    in_ch.mode_request      = '0;
    in_ch.speed_valid       = 1'b0;
    in_ch.speed_mm_s        = '0;
    in_ch.lever_value       = '0;
    in_ch.fault_raise       = 1'b0;
    in_ch.steer_response_ok = 1'b0;
    neutral_q = NEUTRAL_RESET;
    fault_q   = 1'b0;
    pause_q   = 1'b0;
    held_q    = BUCKET_RESET;
    settings = '{12'd0, TGT_MAX, 12'd2452, 12'd3138, 12'd2288,
                 TGT_W'($urandom_range(4095, 0)), NEUTRAL_RESET};

    // directed ticks: calibration ends, bucket edges, overrides, fault recovery
    plan.push_back('{req(1, MODE_AUTO, 0, 0, 0, 0, 0), 1'b1,
                     res(2836, BUCKET_AUTO, MODE_AUTO, 0, 0)});
    plan.push_back('{req(1, MODE_AUTO, 1, -4096, 0, 0, 0), 1'b1,
                     res(2836, BUCKET_AUTO, MODE_AUTO, 0, 0)});
    plan.push_back('{req(1, MODE_AUTO, 1, 4095, 1023, 0, 1), 1'b1,
                     res(2200, BUCKET_AUTO, MODE_AUTO, 0, 0)});
    plan.push_back('{req(1, MODE_AUTO, 1, 0, 0, 0, 0), 1'b1,
                     res(2836, BUCKET_AUTO, MODE_AUTO, 0, 0)});
    plan.push_back('{req(1, MODE_AUTO, 1, 1500, 0, 0, 0), 1'b1,
                     res(2200, BUCKET_AUTO, MODE_AUTO, 0, 0)});
    plan.push_back('{req(1, MODE_AUTO, 1, 400, 0, 0, 0), 1'b0, '0});
    plan.push_back('{req(1, MODE_AUTO, 1, 935, 0, 0, 0), 1'b0, '0});
    plan.push_back('{req(1, MODE_AUTO, 1, 1499, 0, 0, 0), 1'b0, '0});
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 1023, 0, 0), 1'b1,
                     res(3138, 0, MODE_MANUAL, 0, 0)});
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 931, 0, 0), 1'b1,
                     res(3138, 0, MODE_MANUAL, 0, 0)});
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 930, 0, 0), 1'b1,
                     res(3063, 1, MODE_MANUAL, 0, 0)});
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 0, 0, 0), 1'b1,
                     res(2288, 9, MODE_MANUAL, 0, 0)});
    // pause, unknown mode and radio loss keep the held bucket
    plan.push_back('{req(1, MODE_PAUSE, 0, 0, 0, 0, 0), 1'b1,
                     res(2836, 9, MODE_PAUSE, 0, 0)});
    plan.push_back('{req(1, 8'd255, 1, 1000, 1023, 0, 1), 1'b1,
                     res(2836, 9, 8'd255, 0, 0)});
    plan.push_back('{req(0, MODE_MANUAL, 0, 0, 1023, 0, 0), 1'b1,
                     res(2836, 9, MODE_SAFETY, 0, 0)});
    // fault latches after this tick's decision
    plan.push_back('{req(1, MODE_AUTO, 1, 1000, 0, 1, 0), 1'b1,
                     res(2288, BUCKET_AUTO, MODE_AUTO, 1, 0)});
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 600, 0, 1), 1'b1,
                     res(2836, BUCKET_FAULT, MODE_MANUAL, 1, 0)});
    plan.push_back('{req(1, MODE_PAUSE, 0, 0, 0, 0, 0), 1'b1,
                     res(2836, BUCKET_FAULT, MODE_PAUSE, 1, 0)});
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 1023, 0, 1), 1'b1,
                     res(2836, BUCKET_FAULT, MODE_MANUAL, 1, 0)});
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 600, 0, 0), 1'b1,
                     res(2836, BUCKET_FAULT, MODE_MANUAL, 1, 0)});
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 600, 0, 1), 1'b1,
                     res(2836, 4, MODE_MANUAL, 0, 1)});
    plan.push_back('{req(1, MODE_PAUSE, 0, 0, 0, 1, 0), 1'b1,
                     res(2836, 4, MODE_PAUSE, 1, 0)});
    plan.push_back('{req(1, MODE_PAUSE, 0, 0, 0, 0, 0), 1'b1,
                     res(2836, BUCKET_FAULT, MODE_PAUSE, 1, 0)});
    // recovery and a new fault on the same tick
    plan.push_back('{req(1, MODE_MANUAL, 0, 0, 562, 1, 1), 1'b1,
                     res(2836, 4, MODE_MANUAL, 1, 1)});
    // radio loss turns a pause request into safety, so no pause is seen
    plan.push_back('{req(0, MODE_PAUSE, 0, 0, 0, 0, 1), 1'b1,
                     res(2836, BUCKET_FAULT, MODE_SAFETY, 1, 0)});

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) send_item(plan[k].req, plan[k].typed, plan[k].want);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_neutral(settings[p]);
      goal = ticks_sent + PHASE_ITEMS;
      while (ticks_sent < goal) begin
        if ($urandom_range(99, 0) < 8) run_recovery();
        else send_random();
      end
      settle();
    end

    $display("%0d control ticks checked over %0d neutral settings (0 and 4095 included)",
             results_seen, PHASES + 1);
    $display("%0d interpolated auto ticks, %0d fault-hold ticks, %0d fault recoveries",
             interp_ticks, hold_ticks, recoveries);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
